/* design/efc_pkg.sv */
// ---------------------------------------------------------------------------
// efc_pkg: shared types and constants of the event corner detector
// Ring offset tables, the age weight table, arc limits, tau constants and
// the request and response bundles of the quotient divider.
// ---------------------------------------------------------------------------
package efc_pkg;

  // Configuration register indexes.
  localparam logic REG_SENSOR_WIDTH  = 1'b0;
  localparam logic REG_SENSOR_HEIGHT = 1'b1;

  // Distance from every border that an event needs for the arc test.
  localparam int BORDER = 4;

  // Circle sizes and the allowed arc lengths on each circle.
  localparam int RING3_N = 16;
  localparam int RING4_N = 20;
  localparam logic [3:0] ARC3_MIN = 4'd3;
  localparam logic [3:0] ARC3_MAX = 4'd6;
  localparam logic [3:0] ARC4_MIN = 4'd4;
  localparam logic [3:0] ARC4_MAX = 4'd8;

  // Score is (16 - arc3) + (20 - arc4) - 15.
  localparam logic [5:0] SCORE_BIAS = 6'd21;

  // Tau: mean of the five smallest ages, clamped.
  localparam int TAU_CNT     = 5;
  localparam int TAU_MIN     = 50;
  localparam int TAU_MAX     = 50000;
  localparam int TAU_SUM_MAX = 250000;
  localparam int RECIP5      = 52429;
  localparam int RECIP5_SH   = 18;
  localparam int TAU_W       = 16;
  localparam int AGE_W       = 18;

  // Quotient divider widths: age * 256 over 20 * tau.
  localparam int DIV_NUM_W = 26;
  localparam int DIV_DEN_W = 20;
  localparam int QUOT_W    = 6;

  typedef logic signed [3:0] ofs_t;

  localparam ofs_t RING3_DX [RING3_N] = '{
    4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd3, 4'sd3, 4'sd2, 4'sd1,
    4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd3, -4'sd3, -4'sd2, -4'sd1};
  localparam ofs_t RING3_DY [RING3_N] = '{
    4'sd3, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3,
    -4'sd3, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3};
  localparam ofs_t RING4_DX [RING4_N] = '{
    4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4, 4'sd4, 4'sd4, 4'sd3, 4'sd2, 4'sd1,
    4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4, -4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd1};
  localparam ofs_t RING4_DY [RING4_N] = '{
    4'sd4, 4'sd4, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4,
    -4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4};

  // Age weight table in units of 1/4096, built from a Q30 decay chain.
  localparam int WTAB_LEN = 52;
  localparam int WEIGHT_W = 13;
  typedef logic [WEIGHT_W-1:0] wtab_t [WTAB_LEN];

  function automatic wtab_t build_wtab();
    wtab_t      t;
    logic [63:0] a;
    a = 64'd1 << 30;
    for (int q = 0; q < WTAB_LEN; q++) begin
      t[q] = WEIGHT_W'((a + (64'd1 << 17)) >> 18);
      a = (a * 64'd1069555701 + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

  localparam wtab_t WTAB = build_wtab();

  // Divider bundles.
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  // Surface write enables.
  typedef struct packed {
    logic time_we;
    logic score_we;
  } mem_we_t;

endpackage

/* design/efc_surfaces.sv */
// ---------------------------------------------------------------------------
// efc_surfaces: time and score surface memories
// One shared address per cycle; each surface has its own write enable and
// a registered read.
// ---------------------------------------------------------------------------
module efc_surfaces #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17
) (
  input  logic            clk,
  input  logic [AW-1:0]   addr,
  input  efc_pkg::mem_we_t we,
  input  logic [31:0]     wr_time,
  input  logic [3:0]      wr_score,
  output logic [31:0]     rd_time,
  output logic [3:0]      rd_score
);

  logic [31:0] tmem [DEPTH];
  logic [3:0]  smem [DEPTH];

  // Time surface port.
  always_ff @(posedge clk) begin
    if (we.time_we) begin
      tmem[addr] <= wr_time;
    end
    rd_time <= tmem[addr];
  end

  // Score surface port.
  always_ff @(posedge clk) begin
    if (we.score_we) begin
      smem[addr] <= wr_score;
    end
    rd_score <= smem[addr];
  end

endmodule

/* design/efc_qdiv.sv */
// ---------------------------------------------------------------------------
// efc_qdiv: small restoring divider for the weight index
// Finds a six-bit quotient one bit per cycle, most significant bit first.
// ---------------------------------------------------------------------------
module efc_qdiv (
  input  logic               clk,
  input  logic               rst,
  input  efc_pkg::div_req_t  req,
  output efc_pkg::div_rsp_t  rsp
);

  logic [efc_pkg::DIV_NUM_W-1:0] rem;
  logic [efc_pkg::DIV_DEN_W-1:0] den;
  logic [2:0]                    step;
  logic [efc_pkg::QUOT_W-1:0]    quot;
  logic                          busy;
  logic                          done;
  logic [efc_pkg::DIV_NUM_W-1:0] cand;
  logic                          fits;

  // Shifted divisor for the current quotient bit.
  assign cand = efc_pkg::DIV_NUM_W'(den) << step;
  assign fits = rem >= cand;

  // One compare and subtract per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= req.num;
        den  <= req.den;
        step <= 3'(efc_pkg::QUOT_W - 1);
        quot <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - cand;
        end
        quot <= {quot[efc_pkg::QUOT_W-2:0], fits};
        if (step == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 3'd1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

/* design/event_fast_corner_anms_unit.sv */
// ---------------------------------------------------------------------------
// event_fast_corner_anms_unit: event corner detector with adaptive NMS
// Writes each event into a per-polarity time surface, runs the arc test on
// the radius-3 and radius-4 circles, derives tau from the nearest ages and
// suppresses corners that more than one weighted neighbor dominates.
//
//   channel | signals                                   | handshake
//   --------+-------------------------------------------+-----------------
//   input   | pixel_x, pixel_y, polarity, timestamp_us  | in_valid/in_ready
//   result  | in_interior, is_corner, survives_nms      | out_valid/out_ready
//   config  | cfg_index, cfg_data                       | cfg_we, no wait
//
// After reset a clearing pass over all 2*MAX_WIDTH*MAX_HEIGHT entries zeroes both
// surfaces; in_ready stays low meanwhile. An event outside the store or on
// the border goes only through the check, write and done states. An interior
// event fetches each circle of n pixels, tries the candidate arcs one at a time
// on the one compare unit, reads each tau window pixel, forms the tau mean and
// passes each NMS neighbor younger than 4*tau through the shared divider.
// One event is in work at a time; a finished result waits in the output
// register while the next event is accepted.
// ---------------------------------------------------------------------------
module event_fast_corner_anms_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int TAU_RADIUS = 3,
  parameter int NMS_RADIUS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  input  logic        polarity,
  input  logic [31:0] timestamp_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        in_interior,
  output logic        is_corner,
  output logic        survives_nms,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
  localparam int DEPTH = 2 * PLANE;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW    = ($clog2(MAXD) + 2 > 10) ? $clog2(MAXD) + 2 : 10;
  localparam logic signed [3:0] TAU_R = 4'(TAU_RADIUS);
  localparam logic signed [3:0] NMS_R = 4'(NMS_RADIUS);

  typedef enum logic [18:0] {
    S_CLEAR  = 19'h00001,
    S_IDLE   = 19'h00002,
    S_CHECK  = 19'h00004,
    S_WRITE  = 19'h00008,
    S_RING   = 19'h00010,
    S_A_PREV = 19'h00020,
    S_A_HEAD = 19'h00040,
    S_A_NEXT = 19'h00080,
    S_A_TAIL = 19'h00100,
    S_A_SCAN = 19'h00200,
    S_ZERO   = 19'h00400,
    S_SCORE  = 19'h00800,
    S_WIN_RD = 19'h01000,
    S_WIN_WT = 19'h02000,
    S_DIV    = 19'h04000,
    S_TSUM   = 19'h08000,
    S_TDIV   = 19'h10000,
    S_TCLAMP = 19'h20000,
    S_DONE   = 19'h40000
  } state_t;

  state_t state;

  // Configuration and event registers.
  logic [8:0]    sensor_width;
  logic [8:0]    sensor_height;
  logic [7:0]    x_r;
  logic [7:0]    y_r;
  logic          pol_r;
  logic [31:0]   now_r;
  logic [AW-1:0] base;
  logic          interior;
  logic [AW-1:0] clr_cnt;

  // Circle fetch and arc search.
  logic [31:0] vals [efc_pkg::RING4_N];
  logic        r4;
  logic [4:0]  rk;
  logic        rd_pend;
  logic [4:0]  rd_idx;
  logic [4:0]  ai;
  logic [3:0]  as_len;
  logic [4:0]  aj;
  logic [31:0] m;
  logic [31:0] tmp;
  logic [3:0]  a3;
  logic [3:0]  a4;
  logic [3:0]  score;

  // Window walk, tau and suppression.
  logic signed [3:0]  wdx;
  logic signed [3:0]  wdy;
  logic               phase_nms;
  logic [31:0]        best [efc_pkg::TAU_CNT];
  logic [2:0]         nb;
  logic [2:0]         tcnt;
  logic [34:0]        sum;
  logic               tau_big;
  logic [33:0]        tprod;
  logic [efc_pkg::TAU_W-1:0] tau;
  logic [3:0]         nbr_score;
  logic [1:0]         dom;

  // Result held until the output register is free.
  logic res_int;
  logic res_corner;
  logic res_surv;

  // Memory port.
  logic [AW-1:0]     mem_addr;
  efc_pkg::mem_we_t  mem_we;
  logic [31:0]       wr_time;
  logic [3:0]        wr_score;
  logic [31:0]       rd_time;
  logic [3:0]        rd_score;

  efc_pkg::div_req_t div_req;
  efc_pkg::div_rsp_t div_rsp;

  efc_surfaces #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_surf (
    .clk      (clk),
    .addr     (mem_addr),
    .we       (mem_we),
    .wr_time  (wr_time),
    .wr_score (wr_score),
    .rd_time  (rd_time),
    .rd_score (rd_score)
  );

  efc_qdiv u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready = (state == S_IDLE);

  // Border check and base address of the event pixel.
  logic [CW-1:0] xw, yw, wlim, hlim;
  logic          in_store;
  logic          interior_comb;
  logic [AW-1:0] base_comb;

  always_comb begin
    xw   = CW'(x_r);
    yw   = CW'(y_r);
    wlim = (CW'(sensor_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(sensor_width);
    hlim = (CW'(sensor_height) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(sensor_height);
    in_store = (xw < CW'(MAX_WIDTH)) && (yw < CW'(MAX_HEIGHT));
    interior_comb = (xw >= CW'(efc_pkg::BORDER)) && (xw + CW'(efc_pkg::BORDER) < wlim) &&
                    (yw >= CW'(efc_pkg::BORDER)) && (yw + CW'(efc_pkg::BORDER) < hlim);
    base_comb = (pol_r ? AW'(PLANE) : '0) + AW'(AW'(y_r) * AW'(MAX_WIDTH)) + AW'(x_r);
  end

  // Circle geometry and the arc bounds for the circle in use.
  logic [4:0] nlen;
  logic [3:0] arc_lo, arc_hi;
  logic [4:0] ri;

  assign nlen   = r4 ? 5'(efc_pkg::RING4_N) : 5'(efc_pkg::RING3_N);
  assign arc_lo = r4 ? efc_pkg::ARC4_MIN : efc_pkg::ARC3_MIN;
  assign arc_hi = r4 ? efc_pkg::ARC4_MAX : efc_pkg::ARC3_MAX;
  assign ri     = (rk >= nlen) ? 5'd0 : rk;

  // Window walker: radius by phase, step order, last position.
  logic signed [3:0] rad;
  logic              center;
  logic              win_last;
  logic signed [3:0] nxt_wdx, nxt_wdy;

  always_comb begin
    rad      = phase_nms ? NMS_R : TAU_R;
    center   = (wdx == 4'sd0) && (wdy == 4'sd0);
    win_last = (wdx == rad) && (wdy == rad - 4'sd1);
    if (wdy == rad - 4'sd1) begin
      nxt_wdy = -rad;
      nxt_wdx = wdx + 4'sd1;
    end else begin
      nxt_wdy = wdy + 4'sd1;
      nxt_wdx = wdx;
    end
  end

  // Neighbor address: base plus the current offset.
  logic signed [3:0] cur_dx, cur_dy;
  logic [AW-1:0]     offs;

  always_comb begin
    if (state == S_RING) begin
      cur_dx = r4 ? efc_pkg::RING4_DX[ri] : efc_pkg::RING3_DX[ri[3:0]];
      cur_dy = r4 ? efc_pkg::RING4_DY[ri] : efc_pkg::RING3_DY[ri[3:0]];
    end else begin
      cur_dx = wdx;
      cur_dy = wdy;
    end
    offs = AW'(int'(cur_dy) * MAX_WIDTH + int'(cur_dx));
  end

  // Score of the current corner.
  logic [5:0] score_full;
  assign score_full = efc_pkg::SCORE_BIAS - 6'(a3) - 6'(a4);

  // Memory port steering.
  always_comb begin
    mem_addr = base;
    mem_we   = '0;
    wr_time  = now_r;
    wr_score = score_full[3:0];
    case (state)
      S_CLEAR: begin
        mem_addr        = clr_cnt;
        mem_we.time_we  = 1'b1;
        mem_we.score_we = 1'b1;
        wr_time         = '0;
        wr_score        = '0;
      end
      S_WRITE: begin
        mem_we.time_we = in_store;
      end
      S_RING, S_WIN_RD: begin
        mem_addr = base + offs;
      end
      S_ZERO: begin
        mem_we.score_we = 1'b1;
        wr_score        = '0;
      end
      S_SCORE: begin
        mem_we.score_we = 1'b1;
      end
      default: begin
        mem_addr = base;
      end
    endcase
  end

  // Shared compare unit of the arc search: one circle value per cycle.
  logic [4:0]  ridx;
  logic [4:0]  addend;
  logic [5:0]  isum;
  logic [31:0] rv;
  logic        fail_now, pass_now, cand_end, arc_done;
  logic [3:0]  arc_len;
  logic [4:0]  nxt_ai;
  logic [3:0]  nxt_as;

  always_comb begin
    case (state)
      S_A_NEXT: addend = 5'(as_len);
      S_A_TAIL: addend = 5'(as_len) - 5'd1;
      S_A_SCAN: addend = aj;
      default:  addend = 5'd0;
    endcase
    isum = 6'(ai) + 6'(addend);
    if (state == S_A_PREV) begin
      ridx = (ai == 5'd0) ? nlen - 5'd1 : ai - 5'd1;
    end else if (isum >= 6'(nlen)) begin
      ridx = 5'(isum - 6'(nlen));
    end else begin
      ridx = 5'(isum);
    end
    rv = vals[ridx];

    fail_now = ((state == S_A_HEAD) && (rv < tmp)) ||
               ((state == S_A_TAIL) && (rv < tmp)) ||
               ((state == S_A_SCAN) && (5'(as_len) <= aj) && (rv >= m));
    pass_now = (state == S_A_SCAN) && !fail_now && (aj == nlen - 5'd1);
    cand_end = (as_len == arc_hi) && (ai == nlen - 5'd1);
    arc_done = pass_now || (fail_now && cand_end);
    arc_len  = pass_now ? as_len : 4'd0;
    if (as_len == arc_hi) begin
      nxt_as = arc_lo;
      nxt_ai = ai + 5'd1;
    end else begin
      nxt_as = as_len + 4'd1;
      nxt_ai = ai;
    end
  end

  // Age of the fetched neighbor and its sorted insertion among the nearest.
  logic [31:0] age;
  logic        lt [efc_pkg::TAU_CNT];
  logic [31:0] best_ins [efc_pkg::TAU_CNT];

  always_comb begin
    age = (now_r >= rd_time) ? now_r - rd_time : 32'd0;
    for (int k = 0; k < efc_pkg::TAU_CNT; k++) begin
      lt[k] = (3'(k) < nb) ? (best[k] > age) : 1'b1;
    end
    for (int k = 0; k < efc_pkg::TAU_CNT; k++) begin
      if (!lt[k]) begin
        best_ins[k] = best[k];
      end else if (k == 0) begin
        best_ins[k] = age;
      end else if (!lt[k-1]) begin
        best_ins[k] = age;
      end else begin
        best_ins[k] = best[k-1];
      end
    end
  end

  // Suppression: age limits, divider request and the dominance test.
  logic [17:0] tau4;
  logic [19:0] tau20;
  logic        skip;
  logic [efc_pkg::QUOT_W-1:0]   qsel;
  logic [efc_pkg::WEIGHT_W-1:0] wsel;
  logic [16:0] lhs;
  logic [16:0] thr;
  logic        dom_inc;
  logic [1:0]  dom_now;
  logic        adv;
  logic [efc_pkg::TAU_W-1:0] tsel;

  always_comb begin
    tau4  = {tau, 2'b00};
    tau20 = 20'(tau) * 20'd20;
    skip  = age >= 32'(tau4);
    div_req.start = (state == S_WIN_WT) && phase_nms && !skip;
    div_req.num   = {age[efc_pkg::AGE_W-1:0], 8'd0};
    div_req.den   = tau20;
    qsel = (div_rsp.quot > efc_pkg::QUOT_W'(efc_pkg::WTAB_LEN - 1)) ?
           efc_pkg::QUOT_W'(efc_pkg::WTAB_LEN - 1) : div_rsp.quot;
    wsel = efc_pkg::WTAB[qsel];
    lhs  = 17'(wsel) * 17'(nbr_score);
    thr  = {1'b0, score, 12'd0};
    dom_inc = (state == S_DIV) && div_rsp.done && (lhs > thr);
    dom_now = (dom_inc && (dom != 2'd2)) ? dom + 2'd1 : dom;
    adv = ((state == S_WIN_RD) && center) ||
          ((state == S_WIN_WT) && !(phase_nms && !skip)) ||
          ((state == S_DIV) && div_rsp.done);
    tsel = tau_big ? efc_pkg::TAU_W'(efc_pkg::TAU_MAX) : tprod[33:efc_pkg::RECIP5_SH];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_width  <= 9'd240;
      sensor_height <= 9'd180;
    end else if (cfg_we) begin
      case (cfg_index)
        efc_pkg::REG_SENSOR_WIDTH:  sensor_width  <= cfg_data;
        efc_pkg::REG_SENSOR_HEIGHT: sensor_height <= cfg_data;
        default: sensor_width <= sensor_width;
      endcase
    end
  end

  // Circle capture from the registered memory read.
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      vals[rd_idx] <= rd_time;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= (state == S_RING) && (rk < nlen);
      rd_idx  <= rk;
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            x_r   <= pixel_x;
            y_r   <= pixel_y;
            pol_r <= polarity;
            now_r <= timestamp_us;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          base     <= base_comb;
          interior <= in_store && interior_comb;
          state    <= S_WRITE;
        end
        S_WRITE: begin
          r4 <= 1'b0;
          rk <= 5'd0;
          if (!interior) begin
            res_int    <= 1'b0;
            res_corner <= 1'b0;
            res_surv   <= 1'b0;
            state      <= S_DONE;
          end else begin
            state <= S_RING;
          end
        end
        S_RING: begin
          if (rk < nlen) begin
            rk <= rk + 5'd1;
          end else if (!rd_pend) begin
            ai     <= 5'd0;
            as_len <= arc_lo;
            state  <= S_A_PREV;
          end
        end
        S_A_PREV: begin
          tmp   <= rv;
          state <= S_A_HEAD;
        end
        S_A_HEAD: begin
          m <= rv;
          if (!fail_now) begin
            state <= S_A_NEXT;
          end
        end
        S_A_NEXT: begin
          tmp   <= rv;
          state <= S_A_TAIL;
        end
        S_A_TAIL: begin
          aj <= 5'd1;
          if (!fail_now) begin
            state <= S_A_SCAN;
          end
        end
        S_A_SCAN: begin
          if (5'(as_len) > aj && rv < m) begin
            m <= rv;
          end
          aj <= aj + 5'd1;
        end
        S_ZERO: begin
          res_int    <= 1'b1;
          res_corner <= 1'b0;
          res_surv   <= 1'b0;
          state      <= S_DONE;
        end
        S_SCORE: begin
          score      <= score_full[3:0];
          res_int    <= 1'b1;
          res_corner <= 1'b1;
          phase_nms  <= 1'b0;
          nb         <= 3'd0;
          wdx        <= -TAU_R;
          wdy        <= -TAU_R;
          state      <= S_WIN_RD;
        end
        S_WIN_RD: begin
          if (!center) begin
            state <= S_WIN_WT;
          end
        end
        S_WIN_WT: begin
          if (!phase_nms) begin
            for (int k = 0; k < efc_pkg::TAU_CNT; k++) begin
              best[k] <= best_ins[k];
            end
            if (nb != 3'(efc_pkg::TAU_CNT)) begin
              nb <= nb + 3'd1;
            end
          end else if (!skip) begin
            nbr_score <= rd_score;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          dom <= dom_now;
        end
        S_TSUM: begin
          sum <= sum + 35'(best[tcnt]);
          if (tcnt == 3'(efc_pkg::TAU_CNT - 1)) begin
            state <= S_TDIV;
          end else begin
            tcnt <= tcnt + 3'd1;
          end
        end
        S_TDIV: begin
          tau_big <= sum >= 35'(efc_pkg::TAU_SUM_MAX);
          tprod   <= 34'(sum[17:0]) * 34'(efc_pkg::RECIP5);
          state   <= S_TCLAMP;
        end
        S_TCLAMP: begin
          tau       <= (tsel < efc_pkg::TAU_W'(efc_pkg::TAU_MIN)) ?
                       efc_pkg::TAU_W'(efc_pkg::TAU_MIN) : tsel;
          phase_nms <= 1'b1;
          dom       <= 2'd0;
          wdx       <= -NMS_R;
          wdy       <= -NMS_R;
          state     <= S_WIN_RD;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            in_interior  <= res_int;
            is_corner    <= res_corner;
            survives_nms <= res_surv;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Next arc candidate after a failed check.
      if (fail_now && !cand_end) begin
        ai     <= nxt_ai;
        as_len <= nxt_as;
        state  <= S_A_PREV;
      end

      // Arc search finished on the current circle.
      if (arc_done) begin
        if (arc_len == 4'd0) begin
          state <= S_ZERO;
        end else if (!r4) begin
          a3    <= arc_len;
          r4    <= 1'b1;
          rk    <= 5'd0;
          state <= S_RING;
        end else begin
          a4    <= arc_len;
          state <= S_SCORE;
        end
      end

      // Window walker step.
      if (adv) begin
        if (win_last) begin
          if (phase_nms) begin
            res_surv <= (dom_now < 2'd2);
            state    <= S_DONE;
          end else begin
            tcnt  <= 3'd0;
            sum   <= '0;
            state <= S_TSUM;
          end
        end else begin
          wdx   <= nxt_wdx;
          wdy   <= nxt_wdy;
          state <= S_WIN_RD;
        end
      end
    end
  end

endmodule
